/* src/sliding_window_quantiles_top_assert.svh */
`ifndef SLIDING_WINDOW_QUANTILES_TOP_ASSERT_SVH
`define SLIDING_WINDOW_QUANTILES_TOP_ASSERT_SVH

// Same-cycle implication on i_clk, checked only out of reset.
`define SWQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, checked only out of reset.
`define SWQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/swq_pkg.sv */
package swq_pkg;

    localparam int DEF_WINDOW = 64;
    localparam int DATA_W     = 32;
    localparam int HELD_W     = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MEDIAN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_NINETIETH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_NINETY_FIFTH = 2'd2;

    // 100 ms, 200 ms, 300 ms in sixteenths of a millisecond
    localparam logic [DATA_W-1:0] RST_EMPTY_MEDIAN       = 32'd1600;
    localparam logic [DATA_W-1:0] RST_EMPTY_NINETIETH    = 32'd3200;
    localparam logic [DATA_W-1:0] RST_EMPTY_NINETY_FIFTH = 32'd4800;

    // Rank arithmetic: 19 * 1024 still fits, so windows up to 1024 are covered.
    localparam int PCT_W         = 16;
    localparam int PROD_W        = 2 * PCT_W;
    localparam int P90_NUM       = 9;
    localparam int P95_NUM       = 19;
    localparam int RECIP10       = 52429;
    localparam int RECIP10_SHIFT = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_IDX,
        ST_SCAN,
        ST_PICK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic index;
        logic scan;
        logic pick;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic empty;
        logic scan_done;
        logic pick_done;
    } t_status;

    // floor(x / 10), exact for every 16-bit x
    function automatic logic [PCT_W-1:0] div10(input logic [PCT_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(RECIP10);
        return PCT_W'(p >> RECIP10_SHIFT);
    endfunction

endpackage

/* src/sliding_window_quantiles_top.sv */
// Channel   Handshake                      Payload
// -------   ----------------------------   ----------------------------------------
// item in   start high and busy low        i_mode, i_sample
// result    o_result_valid, one cycle      o_median, o_ninetieth, o_ninety_fifth, o_held
// config    i_cfg_we, no wait              i_cfg_idx, i_cfg_data
//
// An add scans the sorted store and then picks the percentiles; a report picks them from
// a non-empty window, and on an empty window presents the configured defaults.
// The add cost is one pass over the sorted store, one entry per cycle through its
// single read port, followed by three reads for the percentiles.
// Reset is synchronous and active low; it empties the window and loads the default
// percentile registers. Both stores hold no reset value and need no clearing pass.
// The result cannot be stalled; busy falls as the result is presented.
`include "sliding_window_quantiles_top_assert.svh"

module sliding_window_quantiles_top #(
    parameter int WINDOW = swq_pkg::DEF_WINDOW
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [swq_pkg::DATA_W-1:0]      i_sample,
    input  logic                            i_cfg_we,
    input  logic [swq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [swq_pkg::DATA_W-1:0]      i_cfg_data,
    output logic                            o_result_valid,
    output logic [swq_pkg::DATA_W-1:0]      o_median,
    output logic [swq_pkg::DATA_W-1:0]      o_ninetieth,
    output logic [swq_pkg::DATA_W-1:0]      o_ninety_fifth,
    output logic [swq_pkg::HELD_W-1:0]      o_held
);
    import swq_pkg::*;

    t_cmd    cmd;
    t_status status;

    swq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    swq_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_mode),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_median       (o_median),
        .o_ninetieth    (o_ninetieth),
        .o_ninety_fifth (o_ninety_fifth),
        .o_held         (o_held)
    );

endmodule

/* src/swq_ctrl.sv */
`include "sliding_window_quantiles_top_assert.svh"

module swq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  swq_pkg::t_status i_status,
    output swq_pkg::t_cmd   o_cmd,
    output logic            o_busy
);
    import swq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_IDX;
            end
            ST_IDX: begin
                o_cmd.index = 1'b1;
                if (i_status.mode) begin
                    n_state = ST_SCAN;
                end else if (i_status.empty) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_PICK;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
                if (i_status.pick_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SWQ_ASSERT_NEXT(a_accept_prep, i_start && !o_busy, r_state == ST_PREP, "accept without prep")
    `SWQ_ASSERT_NEXT(a_emit_idle, o_cmd.emit, r_state == ST_IDLE, "no idle after emit")
    `SWQ_ASSERT_NOW(a_load_idle, o_cmd.load, r_state == ST_IDLE && !o_busy, "load while busy")

endmodule

/* src/swq_dp.sv */
`include "sliding_window_quantiles_top_assert.svh"

module swq_dp #(
    parameter int WINDOW = swq_pkg::DEF_WINDOW
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swq_pkg::t_cmd                   i_cmd,
    output swq_pkg::t_status                o_status,
    input  logic                            i_mode,
    input  logic [swq_pkg::DATA_W-1:0]      i_sample,
    input  logic                            i_cfg_we,
    input  logic [swq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [swq_pkg::DATA_W-1:0]      i_cfg_data,
    output logic                            o_result_valid,
    output logic [swq_pkg::DATA_W-1:0]      o_median,
    output logic [swq_pkg::DATA_W-1:0]      o_ninetieth,
    output logic [swq_pkg::DATA_W-1:0]      o_ninety_fifth,
    output logic [swq_pkg::HELD_W-1:0]      o_held
);
    import swq_pkg::*;

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int KW = CW + 1;
    localparam logic [CW-1:0]     FULL_CNT  = CW'(WINDOW);
    localparam logic [CW:0]       WIN_SUM   = (CW+1)'(WINDOW);
    localparam logic [AW-1:0]     LAST_SLOT = AW'(WINDOW - 1);
    localparam logic [DATA_W-1:0] TOP_VAL   = '1;

    // configuration
    logic [DATA_W-1:0] r_empty_med;
    logic [DATA_W-1:0] r_empty_p90;
    logic [DATA_W-1:0] r_empty_p95;

    // current item
    logic              r_mode;
    logic [DATA_W-1:0] r_sample;

    // window bookkeeping
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_oldest;
    logic              r_del;

    // memories
    logic [DATA_W-1:0] r_ring   [WINDOW];
    logic [DATA_W-1:0] r_sorted [WINDOW];
    logic [DATA_W-1:0] r_rq;
    logic [DATA_W-1:0] r_sq;

    // scan pipeline
    logic [KW-1:0]     r_rk;
    logic [KW-1:0]     r_dk;
    logic              r_dv;
    logic              r_dvirt;
    logic              r_found;
    logic [DATA_W-1:0] r_prev;
    logic [DATA_W-1:0] r_carry;

    // rank selection
    logic [PCT_W-1:0]  r_x90;
    logic [PCT_W-1:0]  r_x95;
    logic [1:0]        r_pk;

    // results
    logic              r_valid;
    logic [DATA_W-1:0] r_med;
    logic [DATA_W-1:0] r_p90;
    logic [DATA_W-1:0] r_p95;
    logic [HELD_W-1:0] r_held;

    logic              full;
    logic [CW:0]       slot_sum;
    logic [CW:0]       slot_wrap;
    logic              ring_we;
    logic [AW-1:0]     ring_wa;
    logic [KW-1:0]     m_len;
    logic              issue;
    logic              rd_real;
    logic [DATA_W-1:0] a_val;
    logic              found_now;
    logic [DATA_W-1:0] b_val;
    logic              b_le;
    logic [DATA_W-1:0] min_val;
    logic [DATA_W-1:0] max_val;
    logic              srt_we;
    logic [AW-1:0]     srt_wa;
    logic [KW-1:0]     dk_m1;
    logic              srt_re;
    logic [AW-1:0]     srt_ra;
    logic [PCT_W-1:0]  pk_idx;
    logic              scan_done;
    logic [31:0]       cnt32;

    always_comb begin
        full      = (r_count == FULL_CNT);
        slot_sum  = (CW+1)'(r_oldest) + (CW+1)'(r_count);
        slot_wrap = (slot_sum >= WIN_SUM) ? (slot_sum - WIN_SUM) : slot_sum;
        ring_we   = i_cmd.prep && r_mode;
        ring_wa   = full ? r_oldest : slot_wrap[AW-1:0];

        // length of the old sorted list that the scan reads
        m_len     = r_del ? KW'(r_count) : (KW'(r_count) - KW'(1));
        issue     = r_rk <= KW'(r_count);
        rd_real   = issue && (r_rk < m_len);

        // entries past the old list read as the top value
        a_val     = r_dvirt ? TOP_VAL : r_sq;
        found_now = r_found || (r_del && (r_prev == r_rq));
        b_val     = found_now ? a_val : r_prev;
        b_le      = (b_val <= r_carry);
        min_val   = b_le ? b_val : r_carry;
        max_val   = b_le ? r_carry : b_val;
        dk_m1     = r_dk - KW'(1);
        srt_we    = i_cmd.scan && r_dv && (r_dk != '0);
        srt_wa    = dk_m1[AW-1:0];
        scan_done = r_dv && (r_dk == KW'(r_count));

        case (r_pk)
            2'd0:    pk_idx = PCT_W'(r_count) >> 1;
            2'd1:    pk_idx = div10(r_x90);
            2'd2:    pk_idx = div10(r_x95) >> 1;
            default: pk_idx = '0;
        endcase
        srt_re = (i_cmd.scan && rd_real) || (i_cmd.pick && (r_pk != 2'd3));
        srt_ra = i_cmd.pick ? pk_idx[AW-1:0] : r_rk[AW-1:0];

        cnt32  = 32'(r_count);
    end

    // configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_med <= RST_EMPTY_MEDIAN;
            r_empty_p90 <= RST_EMPTY_NINETIETH;
            r_empty_p95 <= RST_EMPTY_NINETY_FIFTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EMPTY_MEDIAN:       r_empty_med <= i_cfg_data;
                CFG_EMPTY_NINETIETH:    r_empty_p90 <= i_cfg_data;
                CFG_EMPTY_NINETY_FIFTH: r_empty_p95 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_del    <= 1'b0;
        end else if (i_cmd.prep) begin
            r_del <= r_mode && full;
            if (r_mode) begin
                if (full) begin
                    r_oldest <= (r_oldest == LAST_SLOT) ? '0 : r_oldest + AW'(1);
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    // ring read returns the oldest sample before it is overwritten
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_wa] <= r_sample;
        end
        if (i_cmd.prep) begin
            r_rq <= r_ring[r_oldest];
        end
    end

    always_ff @(posedge i_clk) begin
        if (srt_we) begin
            r_sorted[srt_wa] <= min_val;
        end
        if (srt_re) begin
            r_sq <= r_sorted[srt_ra];
        end
    end

    // one pass: drop the evicted sample, bubble the new one into place
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv    <= 1'b0;
            r_rk    <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.index) begin
            r_dv    <= 1'b0;
            r_rk    <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan) begin
            r_dv <= issue;
            if (issue) begin
                r_rk <= r_rk + KW'(1);
            end
            if (r_dv && (r_dk != '0)) begin
                r_found <= found_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.index) begin
            r_carry <= r_sample;
        end else if (i_cmd.scan) begin
            if (issue) begin
                r_dk    <= r_rk;
                r_dvirt <= !rd_real;
            end
            if (r_dv) begin
                r_prev <= a_val;
                if (r_dk != '0) begin
                    r_carry <= max_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.index) begin
            r_x90 <= PCT_W'(r_count) * PCT_W'(P90_NUM);
            r_x95 <= PCT_W'(r_count) * PCT_W'(P95_NUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk <= '0;
        end else if (i_cmd.index) begin
            r_pk <= '0;
        end else if (i_cmd.pick && (r_pk != 2'd3)) begin
            r_pk <= r_pk + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            case (r_pk)
                2'd1:    r_med <= r_sq;
                2'd2:    r_p90 <= r_sq;
                2'd3:    r_p95 <= r_sq;
                default: begin
                end
            endcase
        end else if (i_cmd.emit && (r_count == '0)) begin
            r_med <= r_empty_med;
            r_p90 <= r_empty_p90;
            r_p95 <= r_empty_p95;
        end
        if (i_cmd.emit) begin
            r_held <= cnt32[HELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_status.mode      = r_mode;
    assign o_status.empty     = (r_count == '0);
    assign o_status.scan_done = scan_done;
    assign o_status.pick_done = (r_pk == 2'd3);

    assign o_result_valid = r_valid;
    assign o_median       = r_med;
    assign o_ninetieth    = r_p90;
    assign o_ninety_fifth = r_p95;
    assign o_held         = r_held;

    `SWQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL_CNT, "fill count above window")
    `SWQ_ASSERT_NOW(a_evict_found, i_cmd.scan && scan_done && r_del, found_now, "evict missed")
    `SWQ_ASSERT_NOW(a_held_count, r_valid, r_held == cnt32[HELD_W-1:0], "held off count")

endmodule

/* dv/swq_quantile_checker.sv */
module swq_quantile_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          mode,
    input  logic [swq_pkg::DATA_W-1:0]    sample,
    input  logic                          cfg_we,
    input  logic [swq_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [swq_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          result_valid,
    input  logic [swq_pkg::DATA_W-1:0]    median,
    input  logic [swq_pkg::DATA_W-1:0]    ninetieth,
    input  logic [swq_pkg::DATA_W-1:0]    ninety_fifth,
    input  logic [swq_pkg::HELD_W-1:0]    held,
    output int                            mismatches,
    output int                            pending
);
    import swq_pkg::*;

    localparam int EXP_DEPTH = 4;

    typedef struct packed {
        logic [DATA_W-1:0] median;
        logic [DATA_W-1:0] ninetieth;
        logic [DATA_W-1:0] ninety_fifth;
        logic [HELD_W-1:0] held;
    } t_quantile_set;

    logic [DATA_W-1:0] arrivals [DEF_WINDOW];
    int unsigned       fill_cnt;
    int unsigned       oldest_idx;
    logic [DATA_W-1:0] empty_p50;
    logic [DATA_W-1:0] empty_p90;
    logic [DATA_W-1:0] empty_p95;
    t_quantile_set     expected_mem [EXP_DEPTH];
    int unsigned       exp_rd;
    int unsigned       exp_wr;
    int unsigned       exp_cnt;

    function automatic int unsigned clamped_rank(int unsigned n, int unsigned num,
                                                 int unsigned den);
        int unsigned r;
        r = (n * num) / den;
        if (r > n - 1) r = n - 1;
        return r;
    endfunction

    function automatic t_quantile_set window_quantiles();
        logic [DATA_W-1:0] ordered [DEF_WINDOW];
        logic [DATA_W-1:0] v;
        int unsigned       n;
        int unsigned       j;
        t_quantile_set     q;
        n = fill_cnt;
        q.held = HELD_W'(n);
        if (n == 0) begin
            q.median       = empty_p50;
            q.ninetieth    = empty_p90;
            q.ninety_fifth = empty_p95;
            return q;
        end
        // insertion sort of the window, oldest first
        for (int unsigned i = 0; i < n; i++) begin
            v = arrivals[(oldest_idx + i) % DEF_WINDOW];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        q.median       = ordered[clamped_rank(n, 1, 2)];
        q.ninetieth    = ordered[clamped_rank(n, P90_NUM, 10)];
        q.ninety_fifth = ordered[clamped_rank(n, P95_NUM, 20)];
        return q;
    endfunction

    always @(posedge clk) begin : watch
        t_quantile_set got;
        t_quantile_set want;
        if (!rst_n) begin
            fill_cnt   = 0;
            oldest_idx = 0;
            empty_p50  = RST_EMPTY_MEDIAN;
            empty_p90  = RST_EMPTY_NINETIETH;
            empty_p95  = RST_EMPTY_NINETY_FIFTH;
            mismatches = 0;
            exp_rd     = 0;
            exp_wr     = 0;
            exp_cnt    = 0;
        end else begin
            if (result_valid) begin
                got = {median, ninetieth, ninety_fifth, held};
                if (exp_cnt == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result p50 %0d p90 %0d p95 %0d held %0d",
                                 $time, median, ninetieth, ninety_fifth, held);
                end else begin
                    want    = expected_mem[exp_rd];
                    exp_rd  = (exp_rd + 1) % EXP_DEPTH;
                    exp_cnt = exp_cnt - 1;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     $time,
                                     want.median, want.ninetieth,
                                     want.ninety_fifth, want.held,
                                     got.median, got.ninetieth,
                                     got.ninety_fifth, got.held);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_EMPTY_MEDIAN:       empty_p50 = cfg_data;
                    CFG_EMPTY_NINETIETH:    empty_p90 = cfg_data;
                    CFG_EMPTY_NINETY_FIFTH: empty_p95 = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (mode) begin
                    if (fill_cnt < DEF_WINDOW) begin
                        arrivals[(oldest_idx + fill_cnt) % DEF_WINDOW] = sample;
                        fill_cnt++;
                    end else begin
                        // overwrite the oldest and advance
                        arrivals[oldest_idx] = sample;
                        oldest_idx = (oldest_idx + 1) % DEF_WINDOW;
                    end
                end
                if (exp_cnt == EXP_DEPTH) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: transfer accepted with results still owed", $time);
                end else begin
                    expected_mem[exp_wr] = window_quantiles();
                    exp_wr  = (exp_wr + 1) % EXP_DEPTH;
                    exp_cnt = exp_cnt + 1;
                end
            end
        end
        pending = int'(exp_cnt);
    end

endmodule

/* dv/tb.sv */
module tb;
    import swq_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 550;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 80;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 i_mode         = 1'b0;
    logic [DATA_W-1:0]    i_sample       = '0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [DATA_W-1:0]    i_cfg_data     = '0;
    logic                 busy;
    logic                 o_result_valid;
    logic [DATA_W-1:0]    o_median;
    logic [DATA_W-1:0]    o_ninetieth;
    logic [DATA_W-1:0]    o_ninety_fifth;
    logic [HELD_W-1:0]    o_held;

    int mismatches;
    int pending;
    int idle_pct    = 0;
    int cycle_count = 0;

    always #6 i_clk = ~i_clk;

    sliding_window_quantiles_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_median       (o_median),
        .o_ninetieth    (o_ninetieth),
        .o_ninety_fifth (o_ninety_fifth),
        .o_held         (o_held)
    );

    swq_quantile_checker u_checker (
        .clk          (i_clk),
        .rst_n        (i_rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (i_mode),
        .sample       (i_sample),
        .cfg_we       (i_cfg_we),
        .cfg_idx      (i_cfg_idx),
        .cfg_data     (i_cfg_data),
        .result_valid (o_result_valid),
        .median       (o_median),
        .ninetieth    (o_ninetieth),
        .ninety_fifth (o_ninety_fifth),
        .held         (o_held),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Enter and leave at a falling edge; returns once the transfer has happened.
    task automatic transfer_item(input logic mode, input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            i_mode   <= 1'($urandom_range(1));
            i_sample <= $urandom;
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_mode   <= mode;
        i_sample <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_IDX_W'($urandom);
        i_cfg_data <= $urandom;
        @(negedge i_clk);
    endtask

    // Mostly small values so duplicates are common, plus extremes and full range.
    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DATA_W'($urandom_range(15));
            5:       return 32'hFFFF_FFF0 | DATA_W'($urandom_range(15));
            6, 7:    return DATA_W'($urandom_range(16000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_default();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int phase_idle [3];
        phase_idle = '{36, 49, 0};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty window: reset defaults, then each register setting
        transfer_item(1'b0, '1);
        wait_drained();
        write_reg(CFG_EMPTY_MEDIAN, '0);
        write_reg(CFG_EMPTY_NINETIETH, '0);
        write_reg(CFG_EMPTY_NINETY_FIFTH, '0);
        transfer_item(1'b0, $urandom);
        wait_drained();
        write_reg(CFG_EMPTY_MEDIAN, '1);
        write_reg(CFG_EMPTY_NINETIETH, '1);
        write_reg(CFG_EMPTY_NINETY_FIFTH, '1);
        // out-of-range index must leave the defaults alone
        write_reg(CFG_UNUSED, '0);
        transfer_item(1'b0, '0);
        wait_drained();
        write_reg(CFG_EMPTY_MEDIAN, $urandom);
        write_reg(CFG_EMPTY_NINETIETH, $urandom);
        write_reg(CFG_EMPTY_NINETY_FIFTH, $urandom);
        transfer_item(1'b0, $urandom);

        // first samples: extremes and duplicates
        transfer_item(1'b1, '1);
        transfer_item(1'b1, '0);
        transfer_item(1'b1, '0);
        transfer_item(1'b0, '1);
        transfer_item(1'b1, 32'h8000_0000);
        transfer_item(1'b1, 32'h7FFF_FFFF);
        transfer_item(1'b1, '1);
        transfer_item(1'b1, 32'd1600);
        transfer_item(1'b1, 32'd1600);
        transfer_item(1'b1, 32'd1);
        transfer_item(1'b0, 32'h5555_5555);
        transfer_item(1'b1, 32'hAAAA_AAAA);

        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            // hold off until every result is back, then retune the defaults
            wait_drained();
            write_reg(CFG_EMPTY_MEDIAN, random_default());
            write_reg(CFG_EMPTY_NINETIETH, random_default());
            write_reg(CFG_EMPTY_NINETY_FIFTH, random_default());
            write_reg(CFG_UNUSED, $urandom);
            repeat (ITEMS_PER_PHASE)
                transfer_item($urandom_range(3) != 0, random_sample());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
